// ===== src/pbe_pkg.sv =====
// Package for the piece bitmap engine: sizes, command codes and state names.
// Used by every module under src; depends on nothing.
package pbe_pkg;

  localparam int MaxBits = 4096;
  localparam int StoreBytes = (MaxBits + 7) / 8;
  localparam int AddrW = $clog2(StoreBytes);
  localparam int PtrW = AddrW + 1;
  localparam int LenW = 13;

  typedef enum logic [2:0] {
    CMD_RESIZE = 3'd0,
    CMD_ASSIGN = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_SETALL = 3'd3,
    CMD_CLRALL = 3'd4,
    CMD_SETBIT = 3'd5,
    CMD_READ   = 3'd6,
    CMD_SPARE  = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Mask that keeps the top rem bits of a byte; rem zero keeps all of them.
  function automatic logic [7:0] tail_mask(input logic [2:0] rem);
    logic [7:0] m;
    m = 8'hFF << (4'd8 - {1'b0, rem});
    if (rem == 3'd0) m = 8'hFF;
    return m;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) n = n + {3'd0, v[k]};
    return n;
  endfunction

endpackage

// ===== src/piece_bitmap_engine.sv =====
// Top level of the piece bitmap engine: command sequencer around one byte memory.
// Depends on pbe_pkg.
//
// One command is taken at a rising edge where start is high and busy is low.
// Every command ends with a scan of all bytes in use through the single memory
// read port, one byte a cycle, to rebuild the population count and first clear
// bit. The summary is on the outputs with done high for exactly the first
// cycle after busy falls; the receiver cannot stall it. Before the scan, assign,
// set all and clear all write every byte in use, a resize writes each byte it
// adds and first patches a partial last byte by read-modify-write when it has
// to, a byte write in range writes one byte and a bit set in range does one
// read-modify-write. The longest command, a resize from a short odd length to
// the full length, keeps busy high longest. Every byte is written before it
// comes inside the length, so the memory needs no clearing pass after reset.
module piece_bitmap_engine (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output logic                     done,
  input  logic [2:0]               cmd,
  input  logic [12:0]              length_value,
  input  logic                     fill,
  input  logic [11:0]              bit_index,
  input  logic [8:0]               byte_index,
  input  logic [7:0]               byte_value,
  output logic [12:0]              set_count,
  output logic [12:0]              first_unset,
  output logic                     all_flag,
  output logic                     empty_flag,
  output logic [12:0]              current_length,
  output logic                     bit_value
);
  import pbe_pkg::*;

  logic [7:0] mem [StoreBytes];
  logic [7:0] rd_data;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [7:0] wr_data;
  logic wr_en;

  state_t state, state_next;
  cmd_t op;
  logic op_fill;
  logic [LenW-1:0] len, old_len, len_next;
  logic [11:0] bidx;
  logic [7:0] yval;
  logic [AddrW-1:0] tgt, tgt_next;          // byte patched or written
  logic [PtrW-1:0] ptr, ptr_next;           // fill and scan pointer
  logic [PtrW-1:0] fill_end, fill_end_next;
  logic scan_pend;                          // read issued last cycle
  logic [AddrW-1:0] scan_addr;
  logic [LenW-1:0] cnt;
  logic [LenW-1:0] first;
  logic found;
  logic bitv;
  logic accept;

  logic [LenW-1:0] sat_len;
  logic [PtrW-1:0] nbytes, new_nbytes;
  logic ptr_last, tgt_last;
  logic [7:0] fill_byte, rmw_set, rmw_byte, wr_byte;

  function automatic logic [2:0] lead_ones(input logic [7:0] v);
    logic [2:0] p;
    p = 3'd0;
    for (int k = 0; k < 8; k++) if (!v[k]) p = 3'(7 - k);
    return p;
  endfunction

  assign accept = (state == ST_IDLE) && start;
  assign sat_len = (length_value > LenW'(MaxBits)) ? LenW'(MaxBits) : length_value;
  assign nbytes = PtrW'((len + LenW'(7)) >> 3);
  assign new_nbytes = PtrW'((sat_len + LenW'(7)) >> 3);
  assign ptr_last = (ptr == nbytes - PtrW'(1));
  assign tgt_last = ({1'b0, tgt} == nbytes - PtrW'(1));

  always_comb begin
    len_next = len;
    if (cmd_t'(cmd) == CMD_RESIZE || cmd_t'(cmd) == CMD_ASSIGN) len_next = sat_len;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Byte that a fill step writes at ptr.
  always_comb begin
    fill_byte = ((op == CMD_SETALL) || (op == CMD_RESIZE && op_fill)) ? 8'hFF : 8'h00;
    if (ptr_last) fill_byte = fill_byte & tail_mask(len[2:0]);
  end

  // Modified byte for the read-modify-write step.
  always_comb begin
    rmw_set = 8'h00;
    if (op == CMD_SETBIT) begin
      rmw_set = 8'h80 >> bidx[2:0];
    end else if (op_fill) begin
      // The old last byte grows with ones: set bits from old_len up to len.
      for (int k = 0; k < 8; k++)
        rmw_set[7-k] = ({1'b0, tgt, 3'(k)} >= old_len) && ({1'b0, tgt, 3'(k)} < len);
    end
    rmw_byte = rd_data | rmw_set;
    if (tgt_last) rmw_byte = rmw_byte & tail_mask(len[2:0]);
  end

  assign wr_byte = tgt_last ? (yval & tail_mask(len[2:0])) : yval;

  always_comb begin
    state_next = state;
    ptr_next = ptr;
    tgt_next = tgt;
    fill_end_next = fill_end;
    wr_en = 1'b0;
    wr_addr = tgt;
    wr_data = rmw_byte;
    rd_addr = tgt;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ptr_next = '0;
          fill_end_next = nbytes;
          tgt_next = bit_index[11:3];
          state_next = ST_SCAN;
          unique case (cmd_t'(cmd)) inside
            CMD_RESIZE: begin
              ptr_next = nbytes;
              fill_end_next = new_nbytes;
              if (sat_len < len) tgt_next = AddrW'(new_nbytes - PtrW'(1));
              else tgt_next = AddrW'(nbytes - PtrW'(1));
              state_next = ((fill && sat_len > len && len[2:0] != 3'd0) ||
                            (sat_len < len && sat_len[2:0] != 3'd0)) ? ST_RMW_RD : ST_FILL;
            end
            CMD_ASSIGN: begin
              fill_end_next = new_nbytes;
              state_next = ST_FILL;
            end
            CMD_SETALL, CMD_CLRALL: state_next = ST_FILL;
            CMD_WRITE: begin
              tgt_next = byte_index;
              if ({1'b0, byte_index} < nbytes) state_next = ST_WRITE;
            end
            CMD_SETBIT: begin
              if ({1'b0, bit_index} < len) state_next = ST_RMW_RD;
            end
            default: state_next = ST_SCAN;
          endcase
        end
      end
      ST_RMW_RD: state_next = ST_RMW_WR;
      ST_RMW_WR: begin
        wr_en = 1'b1;
        state_next = (op == CMD_RESIZE) ? ST_FILL : ST_SCAN;
      end
      ST_WRITE: begin
        wr_en = 1'b1;
        wr_data = wr_byte;
        state_next = ST_SCAN;
      end
      ST_FILL: begin
        if (ptr < fill_end) begin
          wr_en = 1'b1;
          wr_addr = ptr[AddrW-1:0];
          wr_data = fill_byte;
          ptr_next = ptr + PtrW'(1);
        end else begin
          state_next = ST_SCAN;
          ptr_next = '0;
        end
      end
      ST_SCAN: begin
        rd_addr = ptr[AddrW-1:0];
        if (ptr < nbytes) ptr_next = ptr + PtrW'(1);
        else state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ptr <= '0;
      tgt <= '0;
      fill_end <= '0;
      scan_pend <= 1'b0;
      done <= 1'b0;
    end else begin
      ptr <= ptr_next;
      tgt <= tgt_next;
      fill_end <= fill_end_next;
      done <= (state == ST_DONE);
      scan_pend <= (state == ST_SCAN) && (ptr < nbytes);
      scan_addr <= ptr[AddrW-1:0];
      if (accept) begin
        op <= cmd_t'(cmd);
        op_fill <= fill;
        bidx <= bit_index;
        yval <= byte_value;
        old_len <= len;
        len <= len_next;
        cnt <= '0;
        first <= '0;
        found <= 1'b0;
        bitv <= 1'b0;
      end else if (scan_pend) begin
        cnt <= cnt + LenW'(pop8(rd_data));
        // Spare bits read zero, so the first clear bit is capped to the length below.
        if (!found && rd_data != 8'hFF) begin
          found <= 1'b1;
          first <= {1'b0, scan_addr, 3'b000} + LenW'(lead_ones(rd_data));
        end
        if (scan_addr == bidx[11:3]) bitv <= rd_data[3'd7 - bidx[2:0]];
      end
      if (state == ST_DONE) begin
        set_count <= cnt;
        first_unset <= (found && first < len) ? first : len;
        all_flag <= !(found && first < len);
        empty_flag <= (cnt == '0);
        current_length <= len;
        bit_value <= bitv && ({1'b0, bidx} < len);
      end
    end
  end

  assign busy = (state != ST_IDLE);

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held high");
  a_len_cap: assert property (@(posedge clk) disable iff (rst) len <= LenW'(MaxBits))
    else $error("length above maximum");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("transfer did not start work");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while still busy");
`endif

endmodule
